// ----- rtl/core/leb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared types, key codes and limits of the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int unsigned LINE_CAP_DEF   = 64;
  localparam logic [6:0]  MAX_LENGTH_RST = 7'd64;

  // operation codes
  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_PRELOAD = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  // special key codes
  localparam logic [2:0] SK_NONE  = 3'd0;
  localparam logic [2:0] SK_ENTER = 3'd1;
  localparam logic [2:0] SK_LEFT  = 3'd2;
  localparam logic [2:0] SK_RIGHT = 3'd3;
  localparam logic [2:0] SK_HOME  = 3'd4;
  localparam logic [2:0] SK_END   = 3'd5;
  localparam logic [2:0] SK_BACK  = 3'd6;
  localparam logic [2:0] SK_OTHER = 3'd7;

  // character codes
  localparam logic [7:0] KC_CTRL_A = 8'h01;
  localparam logic [7:0] KC_CTRL_B = 8'h02;
  localparam logic [7:0] KC_CTRL_D = 8'h04;
  localparam logic [7:0] KC_CTRL_E = 8'h05;
  localparam logic [7:0] KC_CTRL_F = 8'h06;
  localparam logic [7:0] KC_BEL    = 8'h07;
  localparam logic [7:0] KC_BS     = 8'h08;
  localparam logic [7:0] KC_LF     = 8'h0A;
  localparam logic [7:0] KC_CTRL_K = 8'h0B;
  localparam logic [7:0] KC_CR     = 8'h0D;
  localparam logic [7:0] KC_CTRL_U = 8'h15;
  localparam logic [7:0] KC_ESC    = 8'h1B;
  localparam logic [7:0] KC_SPACE  = 8'h20;
  localparam logic [7:0] KC_DEL    = 8'h7F;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ENTER,
    ACT_CANCEL,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_HOME,
    ACT_END,
    ACT_BACK,
    ACT_DELFWD,
    ACT_KILL,
    ACT_CLEAR,
    ACT_INSERT
  } key_act_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_code;
    logic [2:0] special_key;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic [5:0] position;
    logic       last;
    logic [6:0] line_length;
    logic [6:0] cursor;
    logic       done_res;
    logic       accepted;
  } out_word_t;

endpackage

// ----- rtl/core/leb_keymap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer key map
// Maps a key code and special key to an editing action.
// ----------------------------------------------------------------------------
module leb_keymap (
  input  logic [7:0]         key_code_i,
  input  logic [2:0]         special_key_i,
  output leb_pkg::key_act_e  act_o
);

  leb_pkg::key_act_e code_act;

  always_comb begin
    unique case (key_code_i)
      leb_pkg::KC_LF, leb_pkg::KC_CR:     code_act = leb_pkg::ACT_ENTER;
      leb_pkg::KC_BEL, leb_pkg::KC_ESC:   code_act = leb_pkg::ACT_CANCEL;
      leb_pkg::KC_CTRL_B:                 code_act = leb_pkg::ACT_LEFT;
      leb_pkg::KC_CTRL_F:                 code_act = leb_pkg::ACT_RIGHT;
      leb_pkg::KC_CTRL_A:                 code_act = leb_pkg::ACT_HOME;
      leb_pkg::KC_CTRL_E:                 code_act = leb_pkg::ACT_END;
      leb_pkg::KC_DEL, leb_pkg::KC_BS:    code_act = leb_pkg::ACT_BACK;
      leb_pkg::KC_CTRL_D:                 code_act = leb_pkg::ACT_DELFWD;
      leb_pkg::KC_CTRL_K:                 code_act = leb_pkg::ACT_KILL;
      leb_pkg::KC_CTRL_U:                 code_act = leb_pkg::ACT_CLEAR;
      default: begin
        code_act = (key_code_i >= leb_pkg::KC_SPACE) ? leb_pkg::ACT_INSERT
                                                      : leb_pkg::ACT_NONE;
      end
    endcase
  end

  always_comb begin
    unique case (special_key_i)
      leb_pkg::SK_NONE:  act_o = code_act;
      leb_pkg::SK_ENTER: act_o = leb_pkg::ACT_ENTER;
      leb_pkg::SK_LEFT:  act_o = leb_pkg::ACT_LEFT;
      leb_pkg::SK_RIGHT: act_o = leb_pkg::ACT_RIGHT;
      leb_pkg::SK_HOME:  act_o = leb_pkg::ACT_HOME;
      leb_pkg::SK_END:   act_o = leb_pkg::ACT_END;
      leb_pkg::SK_BACK:  act_o = leb_pkg::ACT_BACK;
      leb_pkg::SK_OTHER: act_o = leb_pkg::ACT_NONE;
      default:           act_o = leb_pkg::ACT_NONE;
    endcase
  end

endmodule

// ----- rtl/core/line_edit_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer
// Keyboard line editor holding the line in a synchronous RAM; edits shift
// the stored characters one at a time, enter streams the line out.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid_i, in_stall_o, in_data_i | key / preload / start words
//  out      | out_valid_o, out_stall_i, out_data_o | status and line characters
//  cfg      | cfg_we_i, cfg_wdata_i            | max_length write
//
// Status-only words are accepted, then wait in status on output stalls.
// Backspace, ctrl-D and insert add a RAM read and a RAM write per character
// moved; insert adds a write of the new character. Enter on a non-empty line
// reads each character from the RAM, then outputs it. One RAM access per cycle.
// Reset: length, cursor, flags clear, max_length = 64; no RAM clearing pass.
// The output register lets the next word in while a result waits.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int unsigned LINE_CAP = leb_pkg::LINE_CAP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  leb_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output leb_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i
);

  localparam int unsigned AW   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam logic [6:0]  CAP7 = 7'(LINE_CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_STATUS,
    S_CH_RD,
    S_CH_OUT
  } state_e;

  state_e             state_q;
  logic [6:0]         max_length_q;
  logic [6:0]         len_q;
  logic [6:0]         cur_q;
  logic               fin_q;
  logic               acc_q;
  logic [6:0]         src_q;
  logic [6:0]         rem_q;
  logic               up_q;
  logic [6:0]         idx_q;
  logic [7:0]         code_q;
  logic [6:0]         put_q;
  logic               out_valid_q;
  leb_pkg::out_word_t out_q;

  logic [7:0]         line_mem [LINE_CAP];
  logic [7:0]         rd_data_q;

  logic               in_acc;
  logic               slot_free;
  logic               out_load;
  logic [6:0]         limit;
  logic [6:0]         sh_dst;
  leb_pkg::key_act_e  act;
  state_e             accept_state;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  leb_keymap u_keymap (
    .key_code_i   (in_data_i.key_code),
    .special_key_i(in_data_i.special_key),
    .act_o        (act)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_load    = slot_free && ((state_q == S_STATUS) || (state_q == S_CH_OUT));
  assign limit       = (max_length_q < CAP7) ? max_length_q : CAP7;
  assign sh_dst      = up_q ? 7'(src_q + 7'd1) : 7'(src_q - 7'd1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // state after an accepted word
  always_comb begin
    accept_state = S_STATUS;
    if ((in_data_i.operation == leb_pkg::OP_KEY) && !fin_q) begin
      unique case (act)
        leb_pkg::ACT_ENTER: begin
          if (len_q != '0) accept_state = S_CH_RD;
        end
        leb_pkg::ACT_BACK: begin
          if ((cur_q != '0) && (len_q != cur_q)) accept_state = S_SH_RD;
        end
        leb_pkg::ACT_DELFWD: begin
          if ((cur_q < len_q) && (7'(len_q - cur_q) != 7'd1)) accept_state = S_SH_RD;
        end
        leb_pkg::ACT_INSERT: begin
          if (len_q < limit) accept_state = (len_q != cur_q) ? S_SH_RD : S_PUT;
        end
        default: ;
      endcase
    end
  end

  // RAM ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      S_IDLE: begin
        wr_en   = in_acc && (in_data_i.operation == leb_pkg::OP_PRELOAD) && !fin_q &&
                  (len_q < limit);
        wr_addr = len_q[AW-1:0];
        wr_data = in_data_i.key_code;
      end
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = src_q[AW-1:0];
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_dst[AW-1:0];
        wr_data = rd_data_q;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = put_q[AW-1:0];
        wr_data = code_q;
      end
      S_CH_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= leb_pkg::MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      fin_q       <= 1'b0;
      acc_q       <= 1'b0;
      src_q       <= '0;
      rem_q       <= '0;
      up_q        <= 1'b0;
      idx_q       <= '0;
      code_q      <= '0;
      put_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= accept_state;
            code_q  <= in_data_i.key_code;
            put_q   <= cur_q;
            priority if (in_data_i.operation == leb_pkg::OP_START) begin
              len_q <= '0;
              cur_q <= '0;
              fin_q <= 1'b0;
              acc_q <= 1'b0;
            end else if (in_data_i.operation == leb_pkg::OP_PRELOAD) begin
              if (!fin_q && (len_q < limit)) begin
                len_q <= 7'(len_q + 7'd1);
                cur_q <= 7'(len_q + 7'd1);
              end
            end else if ((in_data_i.operation == leb_pkg::OP_KEY) && !fin_q) begin
              unique case (act)
                leb_pkg::ACT_ENTER: begin
                  fin_q <= 1'b1;
                  acc_q <= 1'b1;
                  idx_q <= '0;
                end
                leb_pkg::ACT_CANCEL: begin
                  fin_q <= 1'b1;
                  acc_q <= 1'b0;
                end
                leb_pkg::ACT_LEFT: begin
                  if (cur_q != '0) cur_q <= 7'(cur_q - 7'd1);
                end
                leb_pkg::ACT_RIGHT: begin
                  if (cur_q < len_q) cur_q <= 7'(cur_q + 7'd1);
                end
                leb_pkg::ACT_HOME: cur_q <= '0;
                leb_pkg::ACT_END:  cur_q <= len_q;
                leb_pkg::ACT_BACK: begin
                  if (cur_q != '0) begin
                    len_q <= 7'(len_q - 7'd1);
                    cur_q <= 7'(cur_q - 7'd1);
                    src_q <= cur_q;
                    rem_q <= 7'(len_q - cur_q);
                    up_q  <= 1'b0;
                  end
                end
                leb_pkg::ACT_DELFWD: begin
                  if (cur_q < len_q) begin
                    len_q <= 7'(len_q - 7'd1);
                    src_q <= 7'(cur_q + 7'd1);
                    rem_q <= 7'(len_q - cur_q - 7'd1);
                    up_q  <= 1'b0;
                  end
                end
                leb_pkg::ACT_KILL: begin
                  if (cur_q < len_q) len_q <= cur_q;
                end
                leb_pkg::ACT_CLEAR: begin
                  if (cur_q != '0) begin
                    len_q <= '0;
                    cur_q <= '0;
                  end
                end
                leb_pkg::ACT_INSERT: begin
                  if (len_q < limit) begin
                    len_q <= 7'(len_q + 7'd1);
                    cur_q <= 7'(cur_q + 7'd1);
                    src_q <= 7'(len_q - 7'd1);
                    rem_q <= 7'(len_q - cur_q);
                    up_q  <= 1'b1;
                  end
                end
                default: ;
              endcase
            end else begin
            end
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          rem_q <= 7'(rem_q - 7'd1);
          src_q <= up_q ? 7'(src_q - 7'd1) : 7'(src_q + 7'd1);
          if (rem_q == 7'd1) begin
            state_q <= up_q ? S_PUT : S_STATUS;
          end else begin
            state_q <= S_SH_RD;
          end
        end
        S_PUT: state_q <= S_STATUS;
        S_STATUS: begin
          if (slot_free) begin
            out_q <= '{char_out: 8'd0, char_valid: 1'b0, position: 6'd0, last: 1'b1,
                       line_length: len_q, cursor: cur_q, done_res: fin_q,
                       accepted: acc_q};
            state_q <= S_IDLE;
          end
        end
        S_CH_RD: state_q <= S_CH_OUT;
        S_CH_OUT: begin
          if (slot_free) begin
            out_q <= '{char_out: rd_data_q, char_valid: 1'b1, position: idx_q[5:0],
                       last: (7'(idx_q + 7'd1) == len_q),
                       line_length: len_q, cursor: cur_q, done_res: fin_q,
                       accepted: acc_q};
            idx_q <= 7'(idx_q + 7'd1);
            state_q <= (7'(idx_q + 7'd1) == len_q) ? S_IDLE : S_CH_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cur_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q) else $error("cursor beyond line length");

  a_len_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CAP7) else $error("line length beyond capacity");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.operation != leb_pkg::OP_START) && fin_q) |=>
      ($stable(len_q) && $stable(cur_q) && fin_q))
    else $error("finished line changed by a key or preload");

  a_ram_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en)) else $error("RAM read and write in one cycle");
`endif

endmodule
